>>> rtl/pdftse_pkg.sv
`timescale 1ns / 1ps

package pdftse_pkg;

  // Scan phases of the keyword and string tracker
  typedef enum logic [3:0] {
    PH_SEEK    = 4'd0,
    PH_SEEK_B  = 4'd1,
    PH_BLOCK   = 4'd2,
    PH_BLOCK_E = 4'd3,
    PH_STR     = 4'd4,
    PH_STR_E   = 4'd5,
    PH_ESC     = 4'd6,
    PH_STR_EE  = 4'd7,
    PH_DONE    = 4'd8
  } phase_e;

  // Characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N_LO  = 8'h6E;
  localparam logic [7:0] CH_R_LO  = 8'h72;
  localparam logic [7:0] CH_T_LO  = 8'h74;
  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  localparam int unsigned SP_W = 16;
  localparam logic [SP_W-1:0] SP_MAX = '1;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);
  localparam int unsigned MAXRES = 3;

  typedef struct packed {
    logic [SP_W-1:0] spaces_before;
    logic [7:0]      text_byte;
    logic            has_byte;
    logic            end_of_text;
    logic            no_text;
  } res_t;

  // One byte's effect inside a string or an escape
  typedef struct packed {
    phase_e ph;
    logic   sp;   // add one pending space
    logic   ch;   // deliver the character
  } step_t;

  // Classify a kept byte: printable space grows the counter, other printable bytes go out, the rest are dropped
  function automatic step_t keep_step(logic [7:0] c, phase_e ph);
    step_t s;
    s.ph = ph;
    s.sp = 1'b0;
    s.ch = 1'b0;
    if (c inside {[PRINT_LO:PRINT_HI]}) begin
      if (c == CH_SPACE) begin
        s.sp = 1'b1;
      end else begin
        s.ch = 1'b1;
      end
    end
    return s;
  endfunction

  // Plain byte inside a string
  function automatic step_t str_step(logic [7:0] c);
    step_t s;
    s.ph = PH_STR;
    s.sp = 1'b0;
    s.ch = 1'b0;
    if (c == CH_RPAR) begin
      s.sp = 1'b1;
      s.ph = PH_BLOCK;
    end else if (c == CH_BSL) begin
      s.ph = PH_ESC;
    end else if (c == CH_E) begin
      s.ph = PH_STR_E;
    end else begin
      s = keep_step(c, PH_STR);
    end
    return s;
  endfunction

  // Byte inside a text block, outside strings
  function automatic phase_e block_step(logic [7:0] c);
    phase_e ph;
    if (c == CH_LPAR) begin
      ph = PH_STR;
    end else if (c == CH_E) begin
      ph = PH_BLOCK_E;
    end else begin
      ph = PH_BLOCK;
    end
    return ph;
  endfunction

endpackage

>>> rtl/pdftse_if.sv
`timescale 1ns / 1ps

// Raw file byte channel
interface pdftse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

// Extracted text channel
interface pdftse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] spaces_before;
  logic [7:0]  text_byte;
  logic        has_byte;
  logic        end_of_text;
  logic        no_text;

  modport source (output valid, output spaces_before, output text_byte, output has_byte,
                  output end_of_text, output no_text, input ready);
  modport sink   (input valid, input spaces_before, input text_byte, input has_byte,
                  input end_of_text, input no_text, output ready);
endinterface

>>> rtl/pdf_text_string_extractor.sv
`timescale 1ns / 1ps
// Results are registered in the result queue before they appear on out_o.
// Throughput: one byte per cycle while the queue has room; the four-entry result queue takes
// a byte only while it holds at most one request, so a byte that yields two or three results
// stalls the input until out_o has drained the queue back to one request.
// Reset: asynchronous, active low; scanner back to seeking a block, counters and queue empty.
module pdf_text_string_extractor
  import pdftse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  pdftse_in_if.sink          in_i,
  pdftse_out_if.source       out_o
);

  phase_e          phase_q, phase_d;
  logic [SP_W-1:0] pending_q, pending_d;
  logic            seen_q, seen_d;

  res_t            q_mem_q [QDEPTH];
  logic [QAW-1:0]  wr_q, rd_q;
  logic [QCW-1:0]  count_q;

  logic            in_acc, out_acc;
  logic [7:0]      c;
  logic            eof;
  logic            live, fin, fin_e, e1;
  logic            act_sp, act_ch;
  logic [7:0]      ch;
  phase_e          ph_scan;
  step_t           st;
  logic [SP_W-1:0] p;
  logic            s;
  logic [1:0]      res_n;
  res_t            res [MAXRES];

  assign c       = in_i.in_byte;
  assign eof     = in_i.end_of_file;
  assign in_i.ready = (count_q <= QCW'(1));
  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Decode one byte against the current phase
  always_comb begin
    ph_scan = phase_q;
    e1      = 1'b0;
    act_sp  = 1'b0;
    act_ch  = 1'b0;
    ch      = c;
    st      = '{ph: PH_STR, sp: 1'b0, ch: 1'b0};
    live    = (phase_q != PH_DONE);
    fin     = live && ((c == CH_NUL) || eof);
    if (live && (c != CH_NUL)) begin
      case (phase_q)
        PH_SEEK_B: begin
          if (c == CH_T) begin
            ph_scan = PH_BLOCK;
          end else if (c == CH_B) begin
            ph_scan = PH_SEEK_B;
          end else begin
            ph_scan = PH_SEEK;
          end
        end
        PH_BLOCK: begin
          ph_scan = block_step(c);
        end
        PH_BLOCK_E: begin
          ph_scan = (c == CH_T) ? PH_SEEK : block_step(c);
        end
        PH_STR: begin
          st      = str_step(c);
          ph_scan = st.ph;
          act_sp  = st.sp;
          act_ch  = st.ch;
        end
        PH_STR_E: begin
          if (c == CH_T) begin
            act_sp  = 1'b1;
            ph_scan = PH_SEEK;
          end else begin
            e1      = 1'b1;
            st      = str_step(c);
            ph_scan = st.ph;
            act_sp  = st.sp;
            act_ch  = st.ch;
          end
        end
        PH_ESC: begin
          if (c == CH_N_LO) begin
            ch     = CH_LF;
            act_ch = 1'b1;
          end else if (c == CH_R_LO) begin
            ch     = CH_CR;
            act_ch = 1'b1;
          end else if (c == CH_T_LO) begin
            ch     = CH_TAB;
            act_ch = 1'b1;
          end else begin
            st     = keep_step(c, PH_STR);
            act_sp = st.sp;
            act_ch = st.ch;
          end
          ph_scan = (c == CH_E) ? PH_STR_EE : PH_STR;
        end
        PH_STR_EE: begin
          if (c == CH_T) begin
            act_sp  = 1'b1;
            ph_scan = PH_SEEK;
          end else begin
            st      = str_step(c);
            ph_scan = st.ph;
            act_sp  = st.sp;
            act_ch  = st.ch;
          end
        end
        default: begin
          ph_scan = (c == CH_B) ? PH_SEEK_B : PH_SEEK;
        end
      endcase
    end
    fin_e = fin && (ph_scan == PH_STR_E);
  end

  // Build the ordered result list and the next state
  always_comb begin
    p     = pending_q;
    s     = seen_q;
    res_n = 2'd0;
    for (int i = 0; i < MAXRES; i++) begin
      res[i] = '0;
    end
    // deferred 'E' that did not start a keyword
    if (e1) begin
      res[res_n] = '{spaces_before: p, text_byte: CH_E, has_byte: 1'b1,
                     end_of_text: 1'b0, no_text: 1'b0};
      res_n = res_n + 2'd1;
      p     = '0;
      s     = 1'b1;
    end
    if (act_sp) begin
      p = (p == SP_MAX) ? p : p + SP_W'(1);
    end
    if (act_ch) begin
      res[res_n] = '{spaces_before: p, text_byte: ch, has_byte: 1'b1,
                     end_of_text: 1'b0, no_text: 1'b0};
      res_n = res_n + 2'd1;
      p     = '0;
      s     = 1'b1;
    end
    // flush an 'E' still waiting for its lookahead
    if (fin_e) begin
      res[res_n] = '{spaces_before: p, text_byte: CH_E, has_byte: 1'b1,
                     end_of_text: 1'b0, no_text: 1'b0};
      res_n = res_n + 2'd1;
      p     = '0;
      s     = 1'b1;
    end
    // closing marker
    if (fin) begin
      res[res_n] = '{spaces_before: '0, text_byte: CH_NUL, has_byte: 1'b0,
                     end_of_text: 1'b1, no_text: !s};
      res_n = res_n + 2'd1;
    end
    phase_d   = fin ? PH_DONE : ph_scan;
    pending_d = p;
    seen_d    = s;
    // a new file starts after the last byte
    if (eof) begin
      phase_d   = PH_SEEK;
      pending_d = '0;
      seen_d    = 1'b0;
    end
  end

  // Advance scanner state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEEK;
      pending_q <= '0;
      seen_q    <= 1'b0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      seen_q    <= seen_d;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (in_acc) begin
        wr_q <= wr_q + QAW'(res_n);
      end
      if (out_acc) begin
        rd_q <= rd_q + QAW'(1);
      end
      count_q <= count_q + (in_acc ? QCW'(res_n) : QCW'(0)) - (out_acc ? QCW'(1) : QCW'(0));
    end
  end

  // Write the new results into the queue
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MAXRES; i++) begin
        if (2'(i) < res_n) begin
          q_mem_q[wr_q + QAW'(i)] <= res[i];
        end
      end
    end
  end

  // Drive the head request
  assign out_o.valid         = (count_q != '0);
  assign out_o.spaces_before = q_mem_q[rd_q].spaces_before;
  assign out_o.text_byte     = q_mem_q[rd_q].text_byte;
  assign out_o.has_byte      = q_mem_q[rd_q].has_byte;
  assign out_o.end_of_text   = q_mem_q[rd_q].end_of_text;
  assign out_o.no_text       = q_mem_q[rd_q].no_text;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && eof |=> phase_q == PH_SEEK && pending_q == '0 && !seen_q)
    else $error("scanner not back to start after end of file");

  a_zero_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !eof && (c == CH_NUL) && (phase_q != PH_DONE) |=> phase_q == PH_DONE)
    else $error("zero byte did not stop scanning");

  a_seen_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(seen_q) |-> $past(in_acc && eof))
    else $error("text flag cleared without end of file");

endmodule
